// ===== rtl/core/dlps_pkg.sv =====
// Shared constants and helpers for the DDA line pixel stepper.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package dlps_pkg;

    // Default coordinate width.
    localparam int DLPS_COORD_BITS = 12;

    // Entries in the command queue between the front and the back.
    localparam int DLPS_QUEUE_DEPTH = 2;

    // Item kinds carried on the input tuser.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Pixel count codes in a result.
    localparam logic [1:0] PIX_NONE  = 2'd0;
    localparam logic [1:0] PIX_START = 2'd1;
    localparam logic [1:0] PIX_PAIR  = 2'd2;

    // Width of one queued command: step flag, major flag, major start,
    // major end, minor start, major length and signed minor difference.
    function automatic int dlps_cmd_width(input int coord_bits);
        return 5 * coord_bits + 3;
    endfunction

endpackage

// ===== rtl/core/dda_line_pixel_stepper_top.sv =====
// Top level of the DDA line pixel stepper: stream ports, front end, command
// queue and back end. Depends on dlps_pkg, dlps_front, dlps_queue, dlps_back.
`timescale 1ns / 1ps

// Channel    | Direction | Handshake             | Contents
// -----------+-----------+-----------------------+-----------------------------------------
// s_axis     | in        | tvalid / tready       | tuser: action; tdata: line endpoints
// m_axis     | out       | tvalid / tready       | tdata: pixel count and pixels; tlast: done
//
// One item is taken per clock when the result side keeps up; each item gives
// exactly one result. An input transfer passes the input register, one queue
// slot and the result register on its way to the result. The step update is one
// add on the remainder, set by the three parallel remainder sums.
// Reset (i_rst_n low, synchronous) drops any line and empties every stage.
// A stall on m_axis fills the two-entry queue and the input register, after which
// s_axis deasserts tready.

module dda_line_pixel_stepper_top
    import dlps_pkg::*;
#(
    parameter int  COORD_BITS = DLPS_COORD_BITS,
    localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((4 * COORD_BITS + 2 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata, low to high: x_start, y_start, x_end, y_end, zero fill.
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    // tuser: action (0 = load endpoints, 1 = step).
    input  logic             i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // tdata, low to high: pixel_count, first_x, first_y, second_x, second_y, zero fill.
    output logic [OUT_W-1:0] o_m_axis_tdata,
    // tlast: finished, no more pixels follow for the loaded line.
    output logic             o_m_axis_tlast
);

    localparam int CMD_W = dlps_cmd_width(COORD_BITS);

    logic             front_cmd_valid;
    logic             front_cmd_ready;
    logic [CMD_W-1:0] front_cmd;
    logic             back_cmd_valid;
    logic             back_cmd_ready;
    logic [CMD_W-1:0] back_cmd;

    logic [1:0]            pixel_count;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] second_y;

    // The front end registers each transfer and resolves the axis and the
    // endpoint order, so the back end only ever sees rising major coordinates.
    dlps_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .i_x_start   (i_s_axis_tdata[0*COORD_BITS +: COORD_BITS]),
        .i_y_start   (i_s_axis_tdata[1*COORD_BITS +: COORD_BITS]),
        .i_x_end     (i_s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
        .i_y_end     (i_s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
        .o_cmd_valid (front_cmd_valid),
        .i_cmd_ready (front_cmd_ready),
        .o_cmd       (front_cmd)
    );

    // The queue lets the front keep accepting while a result waits downstream.
    dlps_queue #(
        .WIDTH (CMD_W),
        .DEPTH (DLPS_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_cmd_valid),
        .o_push_ready (front_cmd_ready),
        .i_push_data  (front_cmd),
        .o_pop_valid  (back_cmd_valid),
        .i_pop_ready  (back_cmd_ready),
        .o_pop_data   (back_cmd)
    );

    // The back end keeps the minor coordinate as a whole part plus an exact
    // remainder and drives the result register directly.
    dlps_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (back_cmd_valid),
        .o_cmd_ready   (back_cmd_ready),
        .i_cmd         (back_cmd),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_pixel_count (pixel_count),
        .o_first_x     (first_x),
        .o_first_y     (first_y),
        .o_second_x    (second_x),
        .o_second_y    (second_y),
        .o_finished    (o_m_axis_tlast)
    );

    // Pack the result fields from the lowest bit up; the fill bits are zero.
    assign o_m_axis_tdata = OUT_W'({second_y, second_x, first_y, first_x, pixel_count});

endmodule

// ===== rtl/core/dlps_front.sv =====
// Front end of the line stepper: registers incoming items, picks the major
// axis and orders the endpoints, then hands a command to the queue. Uses dlps_pkg.
`timescale 1ns / 1ps

module dlps_front
    import dlps_pkg::*;
#(
    parameter int COORD_BITS = DLPS_COORD_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_action,
    input  logic [COORD_BITS-1:0]                  i_x_start,
    input  logic [COORD_BITS-1:0]                  i_y_start,
    input  logic [COORD_BITS-1:0]                  i_x_end,
    input  logic [COORD_BITS-1:0]                  i_y_end,
    output logic                                   o_cmd_valid,
    input  logic                                   i_cmd_ready,
    output logic [dlps_cmd_width(COORD_BITS)-1:0]  o_cmd
);

    typedef struct packed {
        logic                  step;
        logic                  major_x;
        logic [COORD_BITS-1:0] major_start;
        logic [COORD_BITS-1:0] major_end;
        logic [COORD_BITS-1:0] minor_start;
        logic [COORD_BITS-1:0] major_len;
        logic [COORD_BITS:0]   minor_diff;
    } t_cmd;

    logic                  r_valid;
    logic                  r_step;
    logic                  r_major_x;
    logic [COORD_BITS-1:0] r_xs;
    logic [COORD_BITS-1:0] r_ys;
    logic [COORD_BITS-1:0] r_xe;
    logic [COORD_BITS-1:0] r_ye;
    logic                  n_valid;

    logic                  advance;
    logic [COORD_BITS-1:0] abs_dx;
    logic [COORD_BITS-1:0] abs_dy;

    logic [COORD_BITS-1:0] ms;
    logic [COORD_BITS-1:0] me;
    logic [COORD_BITS-1:0] ns;
    logic [COORD_BITS-1:0] ne;
    logic                  swap;
    t_cmd                  cmd;

    // Input stage: the axis decision is taken on the raw endpoints.
    assign advance = !r_valid || i_cmd_ready;
    assign o_ready = advance;
    assign abs_dx  = (i_x_end >= i_x_start) ? (i_x_end - i_x_start) : (i_x_start - i_x_end);
    assign abs_dy  = (i_y_end >= i_y_start) ? (i_y_end - i_y_start) : (i_y_start - i_y_end);
    assign n_valid = advance ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_step    <= (i_action == ACT_STEP);
            r_major_x <= (abs_dx >= abs_dy);
            r_xs      <= i_x_start;
            r_ys      <= i_y_start;
            r_xe      <= i_x_end;
            r_ye      <= i_y_end;
        end
    end

    // Ordering stage: make the major coordinate rise from start to end.
    assign ms   = r_major_x ? r_xs : r_ys;
    assign me   = r_major_x ? r_xe : r_ye;
    assign ns   = r_major_x ? r_ys : r_xs;
    assign ne   = r_major_x ? r_ye : r_xe;
    assign swap = (ms > me);

    always_comb begin
        cmd.step        = r_step;
        cmd.major_x     = r_major_x;
        cmd.major_start = swap ? me : ms;
        cmd.major_end   = swap ? ms : me;
        cmd.minor_start = swap ? ne : ns;
        cmd.major_len   = swap ? (ms - me) : (me - ms);
        cmd.minor_diff  = swap ? ({1'b0, ns} - {1'b0, ne}) : ({1'b0, ne} - {1'b0, ns});
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = cmd;

endmodule

// ===== rtl/core/dlps_queue.sv =====
// Small register queue that decouples the stepper front end from its back end.
// Uses dlps_pkg for the default depth.
`timescale 1ns / 1ps

module dlps_queue
    import dlps_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DLPS_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/core/dlps_back.sv =====
// Back end of the line stepper: holds the line state, carries out load and
// step commands, and owns the result register. Uses dlps_pkg.
`timescale 1ns / 1ps

module dlps_back
    import dlps_pkg::*;
#(
    parameter int COORD_BITS = DLPS_COORD_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cmd_valid,
    output logic                                   o_cmd_ready,
    input  logic [dlps_cmd_width(COORD_BITS)-1:0]  i_cmd,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [1:0]                             o_pixel_count,
    output logic [COORD_BITS-1:0]                  o_first_x,
    output logic [COORD_BITS-1:0]                  o_first_y,
    output logic [COORD_BITS-1:0]                  o_second_x,
    output logic [COORD_BITS-1:0]                  o_second_y,
    output logic                                   o_finished
);

    localparam int SW = COORD_BITS + 2;

    typedef struct packed {
        logic                  step;
        logic                  major_x;
        logic [COORD_BITS-1:0] major_start;
        logic [COORD_BITS-1:0] major_end;
        logic [COORD_BITS-1:0] minor_start;
        logic [COORD_BITS-1:0] major_len;
        logic [COORD_BITS:0]   minor_diff;
    } t_cmd;

    t_cmd cmd;
    logic pop;

    // Line state.
    logic                  r_active;
    logic                  r_major_x;
    logic [COORD_BITS-1:0] r_pos;
    logic [COORD_BITS-1:0] r_limit;
    logic [COORD_BITS-1:0] r_whole;
    logic [COORD_BITS-1:0] r_rem;
    logic [COORD_BITS-1:0] r_len;
    logic [COORD_BITS:0]   r_diff;
    logic signed [SW-1:0]  r_diff_sub;
    logic signed [SW-1:0]  r_diff_add;

    // Result register.
    logic                  r_o_valid;
    logic [1:0]            r_o_count;
    logic [COORD_BITS-1:0] r_o_ax;
    logic [COORD_BITS-1:0] r_o_ay;
    logic [COORD_BITS-1:0] r_o_bx;
    logic [COORD_BITS-1:0] r_o_by;
    logic                  r_o_last;

    logic                  n_active;
    logic                  n_o_valid;

    // Step datapath: the three remainder candidates are formed in parallel.
    logic signed [SW-1:0]  rem_ext;
    logic signed [SW-1:0]  sum_plain;
    logic signed [SW-1:0]  sum_sub;
    logic signed [SW-1:0]  sum_add;
    logic                  carry_up;
    logic                  carry_down;
    logic [COORD_BITS-1:0] rem_next;
    logic [COORD_BITS-1:0] whole_m1;
    logic [COORD_BITS-1:0] whole_p1;
    logic [COORD_BITS-1:0] whole_p2;
    logic [COORD_BITS-1:0] lo_next;
    logic [COORD_BITS-1:0] hi_next;
    logic [COORD_BITS-1:0] pos_next;
    logic                  step_last;
    logic                  load_active;

    assign cmd         = i_cmd;
    assign pop         = i_cmd_valid && (!r_o_valid || i_ready);
    assign o_cmd_ready = !r_o_valid || i_ready;

    assign rem_ext    = $signed({2'b00, r_rem});
    assign sum_plain  = rem_ext + $signed({r_diff[COORD_BITS], r_diff});
    assign sum_sub    = rem_ext + r_diff_sub;
    assign sum_add    = rem_ext + r_diff_add;
    assign carry_up   = !sum_sub[SW-1];
    assign carry_down = !carry_up && sum_plain[SW-1];

    assign whole_m1 = r_whole - 1'b1;
    assign whole_p1 = r_whole + 1'b1;
    assign whole_p2 = r_whole + 2'd2;

    always_comb begin
        if (carry_up) begin
            rem_next = sum_sub[COORD_BITS-1:0];
            lo_next  = whole_p1;
            hi_next  = whole_p2;
        end else if (carry_down) begin
            rem_next = sum_add[COORD_BITS-1:0];
            lo_next  = whole_m1;
            hi_next  = r_whole;
        end else begin
            rem_next = sum_plain[COORD_BITS-1:0];
            lo_next  = r_whole;
            hi_next  = whole_p1;
        end
        if (rem_next == '0) begin
            hi_next = lo_next;
        end
    end

    assign pos_next    = r_pos + 1'b1;
    assign step_last   = ((r_pos + 2'd2) == r_limit);
    assign load_active = (cmd.major_len > COORD_BITS'(1));

    always_comb begin
        n_active = r_active;
        if (pop) begin
            if (!cmd.step) begin
                n_active = load_active;
            end else if (r_active && step_last) begin
                n_active = 1'b0;
            end
        end
        n_o_valid = pop ? 1'b1 : (i_ready ? 1'b0 : r_o_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_active  <= n_active;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (!cmd.step) begin
                r_major_x  <= cmd.major_x;
                r_pos      <= cmd.major_start;
                r_limit    <= cmd.major_end;
                r_whole    <= cmd.minor_start;
                r_rem      <= '0;
                r_len      <= cmd.major_len;
                r_diff     <= cmd.minor_diff;
                r_diff_sub <= $signed({cmd.minor_diff[COORD_BITS], cmd.minor_diff})
                              - $signed({2'b00, cmd.major_len});
                r_diff_add <= $signed({cmd.minor_diff[COORD_BITS], cmd.minor_diff})
                              + $signed({2'b00, cmd.major_len});
                r_o_count  <= PIX_START;
                r_o_ax     <= cmd.major_x ? cmd.major_start : cmd.minor_start;
                r_o_ay     <= cmd.major_x ? cmd.minor_start : cmd.major_start;
                r_o_bx     <= '0;
                r_o_by     <= '0;
                r_o_last   <= !load_active;
            end else if (r_active) begin
                r_pos     <= pos_next;
                r_whole   <= lo_next;
                r_rem     <= rem_next;
                r_o_count <= PIX_PAIR;
                r_o_ax    <= r_major_x ? pos_next : lo_next;
                r_o_ay    <= r_major_x ? lo_next : pos_next;
                r_o_bx    <= r_major_x ? pos_next : hi_next;
                r_o_by    <= r_major_x ? hi_next : pos_next;
                r_o_last  <= step_last;
            end else begin
                r_o_count <= PIX_NONE;
                r_o_ax    <= '0;
                r_o_ay    <= '0;
                r_o_bx    <= '0;
                r_o_by    <= '0;
                r_o_last  <= 1'b1;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_pixel_count = r_o_count;
    assign o_first_x     = r_o_ax;
    assign o_first_y     = r_o_ay;
    assign o_second_x    = r_o_bx;
    assign o_second_y    = r_o_by;
    assign o_finished    = r_o_last;

    // The remainder stays a proper fraction of the major length.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_rem < r_len))
        else $error("remainder left its range");

    // A line only stays live while at least one step pair is still owed.
    a_live_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_len > COORD_BITS'(1)))
        else $error("live line with major length below two");

    // A step on a dead line yields an empty, final result.
    a_dead_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && cmd.step && !r_active)
        |=> (r_o_valid && (r_o_count == PIX_NONE) && r_o_last))
        else $error("step on idle line gave pixels");

    // A load always yields exactly the start pixel.
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !cmd.step) |=> (r_o_valid && (r_o_count == PIX_START)))
        else $error("load did not report the start pixel");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for dda_line_pixel_stepper_top: directed and random line
// commands go in over the input stream, and every pixel result is checked against a
// built-in line stepper. Depends on dlps_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module testbench;
    import dlps_pkg::*;

    localparam int CB        = DLPS_COORD_BITS;
    localparam int COORD_MAX = (1 << CB) - 1;
    localparam int IN_W      = ((4 * CB + 7) / 8) * 8;
    localparam int OUT_W     = ((4 * CB + 2 + 7) / 8) * 8;

    // Number of random items to queue on top of the directed part.
    localparam int RANDOM_ITEMS = 1075;

    // One input command: the action flag and the two endpoints.
    typedef struct packed {
        logic          action;
        logic [CB-1:0] xs;
        logic [CB-1:0] ys;
        logic [CB-1:0] xe;
        logic [CB-1:0] ye;
    } line_cmd_t;

    // One result: pixel count, the floor (or start) pixel, the ceiling pixel and done.
    typedef struct packed {
        logic [1:0]    count;
        logic [CB-1:0] fx;
        logic [CB-1:0] fy;
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic          done;
    } pixel_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    // The command currently offered on the input stream.
    line_cmd_t s_cmd = '0;

    assign s_tuser = s_cmd.action;
    // Endpoints packed from the lowest bit up: x_start, y_start, x_end, y_end.
    assign s_tdata = IN_W'({s_cmd.ye, s_cmd.xe, s_cmd.ys, s_cmd.xs});

    dda_line_pixel_stepper_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    line_cmd_t     cmd_queue[$];        // commands still to be offered
    pixel_result_t expected_pixels[$];  // predicted results, oldest first
    int            total_lines = 1;
    int            lines_sent = 0;      // commands put on the bus by the driver
    int            lines_accepted = 0;  // input transfers seen
    int            results_checked = 0;
    int            mismatches = 0;

    // Line stepper state: coordinates at the block's width, remainder and deltas one bit wider.
    logic                 ln_active = 1'b0;
    logic                 ln_major_is_x = 1'b0;
    logic [CB-1:0]        ln_pos = '0;
    logic [CB-1:0]        ln_limit = '0;
    logic [CB-1:0]        ln_minor_whole = '0;
    logic signed [CB:0]   ln_rem = '0;
    logic signed [CB:0]   ln_minor_delta = '0;
    logic [CB:0]          ln_major_delta = '0;

    initial begin
        forever #5 clk = ~clk;
    end

    // Advances the mirrored line state by one command and returns the result that
    // the block must produce for it.
    function automatic pixel_result_t predict_pixels(input line_cmd_t c);
        pixel_result_t r;
        int xs, ys, xe, ye, adx, ady, ms, me, ns, ne, t, rem;
        logic [CB-1:0] hi;
        r = '0;
        if (c.action == ACT_LOAD) begin
            xs = int'(c.xs);
            ys = int'(c.ys);
            xe = int'(c.xe);
            ye = int'(c.ye);
            adx = (xe >= xs) ? xe - xs : xs - xe;
            ady = (ye >= ys) ? ye - ys : ys - ye;
            // Ties go to x as the major axis.
            ln_major_is_x = (adx >= ady);
            if (ln_major_is_x) begin
                ms = xs; me = xe; ns = ys; ne = ye;
            end else begin
                ms = ys; me = ye; ns = xs; ne = xe;
            end
            // Walk the major axis upward; the minor endpoints swap along with it.
            if (ms > me) begin
                t = ms; ms = me; me = t;
                t = ns; ns = ne; ne = t;
            end
            ln_pos = ms[CB-1:0];
            ln_limit = me[CB-1:0];
            ln_minor_whole = ns[CB-1:0];
            ln_rem = '0;
            ln_major_delta = (CB + 1)'(me - ms);
            ln_minor_delta = (CB + 1)'(ne - ns);
            // A line of major length zero or one has nothing beyond its start pixel.
            ln_active = ((me - ms) >= 2);
            r.count = PIX_START;
            r.fx = ln_major_is_x ? ms[CB-1:0] : ns[CB-1:0];
            r.fy = ln_major_is_x ? ns[CB-1:0] : ms[CB-1:0];
            r.done = !ln_active;
        end else if (!ln_active) begin
            r.count = PIX_NONE;
            r.done = 1'b1;
        end else begin
            ln_pos = ln_pos + 1'b1;
            // The remainder stays in [0, major length); one correction is enough
            // because the minor difference never exceeds the major length.
            rem = int'(ln_rem) + int'(ln_minor_delta);
            if (rem >= int'(ln_major_delta)) begin
                rem = rem - int'(ln_major_delta);
                ln_minor_whole = ln_minor_whole + 1'b1;
            end else if (rem < 0) begin
                rem = rem + int'(ln_major_delta);
                ln_minor_whole = ln_minor_whole - 1'b1;
            end
            ln_rem = rem[CB:0];
            hi = ln_minor_whole + ((rem != 0) ? 1'b1 : 1'b0);
            // The end pixel itself is never plotted.
            r.done = (CB'(ln_pos + 1'b1) == ln_limit);
            if (r.done) ln_active = 1'b0;
            r.count = PIX_PAIR;
            r.fx = ln_major_is_x ? ln_pos : ln_minor_whole;
            r.fy = ln_major_is_x ? ln_minor_whole : ln_pos;
            r.sx = ln_major_is_x ? ln_pos : hi;
            r.sy = ln_major_is_x ? hi : ln_pos;
        end
        return r;
    endfunction

    // Prints one line per mismatch and counts it; printing stops after a hundred
    // so that a badly broken block does not flood the log.
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100) $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_checked, name, got, want));
    endtask

    // Idle share of the sender or the receiver, by how far the run has come:
    // first the sender idles lightly and the receiver heavily, then the reverse,
    // then both run flat out.
    function automatic int idle_percent(input bit for_sender);
        int phase;
        phase = (lines_accepted * 3) / total_lines;
        if (phase == 0) return for_sender ? 23 : 65;
        if (phase == 1) return for_sender ? 65 : 23;
        return 0;
    endfunction

    function automatic logic [CB-1:0] clamp_coord(input int v);
        if (v < 0) return '0;
        if (v > COORD_MAX) return COORD_MAX[CB-1:0];
        return v[CB-1:0];
    endfunction

    task automatic push_load(input int xs, input int ys, input int xe, input int ye);
        line_cmd_t c;
        c.action = ACT_LOAD;
        c.xs = xs[CB-1:0];
        c.ys = ys[CB-1:0];
        c.xe = xe[CB-1:0];
        c.ye = ye[CB-1:0];
        cmd_queue.push_back(c);
    endtask

    // Step commands carry random endpoint bits, which the block must ignore.
    task automatic push_steps(input int n);
        line_cmd_t c;
        for (int i = 0; i < n; i++) begin
            c.action = ACT_STEP;
            c.xs = CB'($urandom);
            c.ys = CB'($urandom);
            c.xe = CB'($urandom);
            c.ye = CB'($urandom);
            cmd_queue.push_back(c);
        end
    endtask

    // A well-formed line: a load, then the steps that walk it. Most lines are short;
    // some are cut off by the next load and some are stepped past their end.
    task automatic push_random_line();
        int x0, y0, x1, y1, len, span, steps;
        x0 = $urandom_range(COORD_MAX);
        y0 = $urandom_range(COORD_MAX);
        len = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(24);
        x1 = int'(clamp_coord(x0 + int'($urandom_range(2 * len)) - len));
        y1 = int'(clamp_coord(y0 + int'($urandom_range(2 * len)) - len));
        span = (x1 > x0) ? x1 - x0 : x0 - x1;
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > span) span = (y1 > y0) ? y1 - y0 : y0 - y1;
        steps = (span > 0) ? span - 1 : 0;
        case ($urandom_range(9))
            0: steps = $urandom_range(steps);
            1: steps = steps + $urandom_range(3, 1);
            default: ;
        endcase
        push_load(x0, y0, x1, y1);
        push_steps(steps);
    endtask

    // Noise: a few commands with random action and random endpoints.
    task automatic push_noise();
        line_cmd_t c;
        repeat ($urandom_range(4, 1)) begin
            c = line_cmd_t'({$urandom, $urandom});
            cmd_queue.push_back(c);
        end
    endtask

    // Driver: offers the next queued command at the falling edge, holding the
    // current one until its transfer has taken place.
    always @(negedge clk) begin : drive_commands
        line_cmd_t c;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || lines_accepted == lines_sent) begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_percent(1'b1)) begin
                c = cmd_queue.pop_front();
                lines_sent++;
                s_cmd <= c;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= idle_percent(1'b0));
    end

    // Monitor: checks each result transfer against the oldest prediction first,
    // then records the prediction for an input transfer at the same edge.
    always @(posedge clk) begin : check_results
        pixel_result_t got;
        pixel_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.count = m_tdata[1:0];
            got.fx = m_tdata[2 +: CB];
            got.fy = m_tdata[2 + CB +: CB];
            got.sx = m_tdata[2 + 2 * CB +: CB];
            got.sy = m_tdata[2 + 3 * CB +: CB];
            got.done = m_tlast;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none pending",
                                          results_checked));
            end else begin
                want = expected_pixels.pop_front();
                check_field("pixel_count", 32'(got.count), 32'(want.count));
                check_field("first_x", 32'(got.fx), 32'(want.fx));
                check_field("first_y", 32'(got.fy), 32'(want.fy));
                check_field("second_x", 32'(got.sx), 32'(want.sx));
                check_field("second_y", 32'(got.sy), 32'(want.sy));
                check_field("finished", 32'(got.done), 32'(want.done));
            end
            results_checked++;
        end
        if (rst_n && s_tvalid && s_tready) begin
            expected_pixels.push_back(predict_pixels(s_cmd));
            lines_accepted++;
        end
    end

    // Stimulus and end of run.
    initial begin
        // A step straight after reset finds no line.
        push_steps(1);
        // Full-range diagonal, then a new load drops it after one step; the second
        // line runs with the endpoints swapped and a falling minor coordinate.
        push_load(0, 0, COORD_MAX, COORD_MAX);
        push_steps(1);
        push_load(COORD_MAX, 0, 0, COORD_MAX);
        push_steps(1);
        // Zero-length line, then a step that finds it done.
        push_load(100, 200, 100, 200);
        push_steps(1);
        // Major length one.
        push_load(10, 10, 11, 11);
        push_steps(1);
        // Steep line given end first: y is the major axis.
        push_load(50, 60, 47, 52);
        push_steps(7);
        // Shallow line at the top corner, endpoints reversed.
        push_load(COORD_MAX, COORD_MAX, COORD_MAX - 5, COORD_MAX - 2);
        push_steps(4);
        // Horizontal line along the top row.
        push_load(0, COORD_MAX, 3, COORD_MAX);
        push_steps(2);

        while (cmd_queue.size() < 25 + RANDOM_ITEMS) begin
            if ($urandom_range(99) < 85) push_random_line();
            else push_noise();
        end
        total_lines = cmd_queue.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (lines_accepted < total_lines || expected_pixels.size() > 0) @(posedge clk);
        // Give a late stray result the chance to show up.
        repeat (10) @(posedge clk);

        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== dda_line_pixel_stepper_top.f =====
rtl/core/dlps_pkg.sv
rtl/core/dlps_front.sv
rtl/core/dlps_queue.sv
rtl/core/dlps_back.sv
rtl/core/dda_line_pixel_stepper_top.sv
bench/testbench.sv
